// ===== sv/psc_pkg.sv =====
package psc_pkg;

    localparam int WordW  = 16;
    localparam int RawW   = 24;
    localparam int IndexW = 3;
    localparam int TempW  = 19;
    localparam int PresW  = 24;

    localparam logic [IndexW-1:0] REG_CRC_WORD  = 3'd0;
    localparam logic [IndexW-1:0] REG_SENS      = 3'd1;
    localparam logic [IndexW-1:0] REG_OFFSET    = 3'd2;
    localparam logic [IndexW-1:0] REG_TCS       = 3'd3;
    localparam logic [IndexW-1:0] REG_TCO       = 3'd4;
    localparam logic [IndexW-1:0] REG_TREF      = 3'd5;
    localparam logic [IndexW-1:0] REG_TEMPSENS  = 3'd6;

    localparam logic [WordW-1:0] CRC_POLY      = 16'h3000;
    localparam logic [WordW-1:0] WORD0_MASK    = 16'h0FFF;
    localparam int               CRC_BYTES     = 16;

    localparam logic signed [TempW-1:0] TEMP_BASE = 19'sd2000;
    localparam logic signed [TempW-1:0] TEMP_MAX  = 19'sd8500;
    localparam logic signed [TempW-1:0] TEMP_MIN  = -19'sd4000;
    localparam logic signed [26:0]      PRES_MAX  = 27'sd300000;
    localparam logic signed [26:0]      PRES_MIN  = 27'sd20;

    typedef struct packed {
        logic [WordW-1:0] word0;
        logic [WordW-1:0] c1;
        logic [WordW-1:0] c2;
        logic [WordW-1:0] c3;
        logic [WordW-1:0] c4;
        logic [WordW-1:0] c5;
        logic [WordW-1:0] c6;
    } cal_t;

    typedef struct packed {
        logic busy;
        logic ok;
    } crc_status_t;

endpackage

// ===== sv/psc_if.sv =====
interface psc_in_if;
    import psc_pkg::*;

    logic              valid;
    logic              ready;
    logic [RawW-1:0]   pressure_raw;
    logic [RawW-1:0]   temperature_raw;

    modport source (output valid, pressure_raw, temperature_raw, input ready);
    modport sink   (input valid, pressure_raw, temperature_raw, output ready);
endinterface

interface psc_out_if;
    import psc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [TempW-1:0] temperature_centi;
    logic signed [PresW-1:0] pressure_tenth_mbar;
    logic                    out_of_range;
    logic                    prom_crc_ok;

    modport source (output valid, temperature_centi, pressure_tenth_mbar, out_of_range,
                    prom_crc_ok, input ready);
    modport sink   (input valid, temperature_centi, pressure_tenth_mbar, out_of_range,
                    prom_crc_ok, output ready);
endinterface

interface psc_cfg_if;
    import psc_pkg::*;

    logic              valid;
    logic              ready;
    logic [IndexW-1:0] index;
    logic [WordW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/psc_crc.sv =====
module psc_crc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  psc_pkg::cal_t       cal,
    output psc_pkg::crc_status_t status
);
    import psc_pkg::*;

    logic             busy_reg;
    logic             ok_reg;
    logic [3:0]       cnt_reg;
    logic [WordW-1:0] rem_reg;
    logic [WordW-1:0] word;
    logic [7:0]       byte_sel;
    logic [WordW-1:0] rem_next;

    always_comb
    begin
        case (cnt_reg[3:1])
            REG_CRC_WORD: word = cal.word0 & WORD0_MASK;
            REG_SENS:     word = cal.c1;
            REG_OFFSET:   word = cal.c2;
            REG_TCS:      word = cal.c3;
            REG_TCO:      word = cal.c4;
            REG_TREF:     word = cal.c5;
            REG_TEMPSENS: word = cal.c6;
            default:      word = '0;
        endcase
    end

    assign byte_sel = cnt_reg[0] ? word[7:0] : word[15:8];

    always_comb
    begin
        rem_next = rem_reg ^ {8'h00, byte_sel};
        for (int b = 0; b < 8; b++)
        begin
            if (rem_next[15])
                rem_next = (rem_next << 1) ^ CRC_POLY;
            else
                rem_next = rem_next << 1;
        end
    end

    // one byte per cycle; restarted by reset and by every register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            ok_reg   <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'(CRC_BYTES - 1))
            begin
                busy_reg <= 1'b0;
                ok_reg   <= (rem_next[15:12] == cal.word0[15:12]);
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.ok   = ok_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("crc engine not busy after restart");

endmodule

// ===== sv/psc_pipe.sv =====
module psc_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psc_pkg::cal_t        cal,
    input  psc_pkg::crc_status_t crc,
    psc_in_if.sink               sample,
    psc_out_if.source            result
);
    import psc_pkg::*;

    localparam int Stages = 6;

    logic [Stages-1:0] v_reg;
    logic [Stages:0]   rdy;
    logic              take;

    always_comb
    begin
        rdy[Stages] = result.ready;
        for (int k = Stages - 1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign sample.ready = rdy[0] && !crc.busy;
    assign take         = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= take;
            for (int k = 1; k < Stages; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage 1: dT
    logic [RawW-1:0]    d1_s1_reg;
    logic signed [24:0] dt_s1_reg;
    logic signed [24:0] dt_next;

    assign dt_next = $signed({1'b0, sample.temperature_raw}) - $signed({1'b0, cal.c5, 8'h00});

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            d1_s1_reg <= sample.pressure_raw;
            dt_s1_reg <= dt_next;
        end
    end

    // stage 2: dT products
    logic [RawW-1:0]    d1_s2_reg;
    logic signed [41:0] mt_s2_reg;
    logic signed [41:0] mo_s2_reg;
    logic signed [41:0] ms_s2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            d1_s2_reg <= d1_s1_reg;
            mt_s2_reg <= 42'(dt_s1_reg) * 42'($signed({1'b0, cal.c6}));
            mo_s2_reg <= 42'(dt_s1_reg) * 42'($signed({1'b0, cal.c4}));
            ms_s2_reg <= 42'(dt_s1_reg) * 42'($signed({1'b0, cal.c3}));
        end
    end

    // stage 3: TEMP, OFF, SENS
    logic [RawW-1:0]         d1_s3_reg;
    logic signed [TempW-1:0] temp_s3_reg;
    logic signed [35:0]      off_s3_reg;
    logic signed [34:0]      sens_s3_reg;
    logic signed [41:0]      mt_adj;

    // truncate toward zero
    assign mt_adj = mt_s2_reg + (mt_s2_reg[41] ? 42'sd8388607 : 42'sd0);

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            d1_s3_reg   <= d1_s2_reg;
            temp_s3_reg <= $signed(mt_adj[41:23]) + TEMP_BASE;
            off_s3_reg  <= $signed({4'h0, cal.c2, 16'h0000}) + 36'($signed(mo_s2_reg[41:7]));
            sens_s3_reg <= $signed({4'h0, cal.c1, 15'h0000}) + 35'($signed(ms_s2_reg[41:8]));
        end
    end

    // stage 4: D1 * SENS as two partial products
    logic signed [TempW-1:0] temp_s4_reg;
    logic signed [35:0]      off_s4_reg;
    logic [40:0]             pl_s4_reg;
    logic signed [42:0]      ph_s4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            temp_s4_reg <= temp_s3_reg;
            off_s4_reg  <= off_s3_reg;
            pl_s4_reg   <= 41'(d1_s3_reg) * 41'(sens_s3_reg[16:0]);
            ph_s4_reg   <= 43'($signed({1'b0, d1_s3_reg})) * 43'($signed(sens_s3_reg[34:17]));
        end
    end

    // stage 5: combine, shift, subtract OFF
    logic signed [TempW-1:0] temp_s5_reg;
    logic signed [39:0]      diff_s5_reg;
    logic signed [59:0]      full;

    assign full = $signed({ph_s4_reg, 17'h00000}) + $signed({19'h00000, pl_s4_reg});

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            temp_s5_reg <= temp_s4_reg;
            diff_s5_reg <= 40'($signed(full[59:21])) - 40'(off_s4_reg);
        end
    end

    // stage 6: P and range check
    logic signed [TempW-1:0] temp_s6_reg;
    logic signed [PresW-1:0] p_s6_reg;
    logic                    bad_s6_reg;
    logic signed [26:0]      p_full;

    assign p_full = $signed(diff_s5_reg[39:13]);

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            temp_s6_reg <= temp_s5_reg;
            p_s6_reg    <= $signed(p_full[PresW-1:0]);
            bad_s6_reg  <= (temp_s5_reg > TEMP_MAX) || (temp_s5_reg < TEMP_MIN)
                        || (p_full > PRES_MAX) || (p_full < PRES_MIN);
        end
    end

    assign result.valid               = v_reg[Stages-1];
    assign result.temperature_centi   = temp_s6_reg;
    assign result.pressure_tenth_mbar = p_s6_reg;
    assign result.out_of_range        = bad_s6_reg;
    assign result.prom_crc_ok         = crc.ok;

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> v_reg[0])
        else $error("accepted beat not captured in first stage");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[Stages-1] && !result.ready |=> v_reg[Stages-1] && $stable(p_s6_reg))
        else $error("stalled result changed");

    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        crc.busy |-> !sample.ready)
        else $error("input ready during crc pass");

endmodule

// ===== sv/pressure_sensor_compensation.sv =====
// Pressure sensor first-order compensation. Takes one beat of raw D1/D2
// conversions per cycle and returns compensated temperature (0.01 C),
// pressure (0.1 mbar), a plausibility flag and the PROM CRC4 flag. It is
// a six-stage pipeline (dT, products, TEMP/OFF/SENS, split D1*SENS
// product, combine, P and range check); throughput is one beat per cycle
// while the output is taken and no CRC pass runs. The CRC is computed by a
// byte-serial engine: after reset and after every register write it runs a
// pass over 16 bytes, during which no input beat is accepted.
module pressure_sensor_compensation (
    input  logic       clk,
    input  logic       rst_n,
    psc_cfg_if.sink    cfg,
    psc_in_if.sink     sample,
    psc_out_if.source  result
);
    import psc_pkg::*;

    cal_t        cal_reg;
    crc_status_t crc_st;
    logic        cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg.index)
                REG_CRC_WORD: cal_reg.word0 <= cfg.data;
                REG_SENS:     cal_reg.c1    <= cfg.data;
                REG_OFFSET:   cal_reg.c2    <= cfg.data;
                REG_TCS:      cal_reg.c3    <= cfg.data;
                REG_TCO:      cal_reg.c4    <= cfg.data;
                REG_TREF:     cal_reg.c5    <= cfg.data;
                REG_TEMPSENS: cal_reg.c6    <= cfg.data;
                default:      ;
            endcase
        end
    end

    psc_crc u_crc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_we),
        .cal    (cal_reg),
        .status (crc_st)
    );

    psc_pipe u_pipe (
        .clk    (clk),
        .rst_n  (rst_n),
        .cal    (cal_reg),
        .crc    (crc_st),
        .sample (sample),
        .result (result)
    );

endmodule
